@@ rtl/core/dsf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dsf_pkg: shared types, constants and functions
// Widths, register indexes, scale codes and segment codes of the decimal
// seven-segment formatter.
// ----------------------------------------------------------------------------
package dsf_pkg;

   localparam int READING_W   = 20;
   localparam int DOT_W       = 3;
   localparam int SCALE_W     = 3;
   localparam int DIGITS      = 7;              // BCD digits of a 20-bit value
   localparam int BCD_W       = 4 * DIGITS;
   localparam int BCD_STAGES  = 4;
   localparam int STAGE_STEPS = READING_W / BCD_STAGES;
   localparam int POSITIONS   = 6;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 3;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_SELECT      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEADING_ZERO_FILL = 1'd1;

   localparam logic [SCALE_W-1:0] SCALE_RESET         = 3'd6;
   localparam logic [SCALE_W-1:0] SCALE_DIV10         = 3'd4;
   localparam logic [SCALE_W-1:0] SCALE_DIV100        = 3'd3;
   localparam logic [SCALE_W-1:0] SCALE_DIV1000_LOW   = 3'd0;
   localparam logic [SCALE_W-1:0] SCALE_DIV1000_HIGH  = 3'd2;

   localparam logic [DOT_W-1:0] DOT_POS0     = 3'd6;
   localparam logic [DOT_W-1:0] DOT_POS1     = 3'd5;
   localparam logic [DOT_W-1:0] DOT_POS2     = 3'd4;
   localparam logic [DOT_W-1:0] DOT_POS3     = 3'd3;
   localparam logic [DOT_W-1:0] DOT_POS4_LOW = 3'd0;
   localparam logic [DOT_W-1:0] DOT_POS4_HI  = 3'd2;

   localparam logic [7:0] SEG_BLANK = 8'h00;
   localparam logic [7:0] SEG_MINUS = 8'h40;
   localparam logic [7:0] SEG_POINT = 8'h80;

   typedef logic [7:0] seg_type;
   typedef seg_type [POSITIONS-1:0] seg_row_type;

   // one word on its way through the binary-to-BCD stages
   typedef struct packed {
      logic [BCD_W-1:0]     bcd;
      logic [READING_W-1:0] bin;
      logic [DOT_W-1:0]     dot;
      logic                 neg;
   } bcd_word_type;

   function automatic seg_type digit_seg(input logic [3:0] digit);
      seg_type code;
      case (digit)
         4'd0:    code = 8'h3f;
         4'd1:    code = 8'h06;
         4'd2:    code = 8'h5b;
         4'd3:    code = 8'h4f;
         4'd4:    code = 8'h66;
         4'd5:    code = 8'h6d;
         4'd6:    code = 8'h7d;
         4'd7:    code = 8'h27;
         4'd8:    code = 8'h7f;
         4'd9:    code = 8'h6f;
         default: code = SEG_BLANK;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/dsf_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dsf_req_if: request channel
// Valid/ready channel carrying one reading word.
// ----------------------------------------------------------------------------
interface dsf_req_if;
   logic                             valid;
   logic                             ready;
   logic [dsf_pkg::READING_W-1:0]    reading;
   logic [dsf_pkg::DOT_W-1:0]        dot_position;
   logic                             negative;

   modport source (output valid, output reading, output dot_position, output negative,
                   input ready);
   modport sink   (input valid, input reading, input dot_position, input negative,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/core/dsf_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dsf_rsp_if: response channel
// Valid/ready channel carrying six segment codes.
// ----------------------------------------------------------------------------
interface dsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] seg_pos0;
   logic [7:0] seg_pos1;
   logic [7:0] seg_pos2;
   logic [7:0] seg_pos3;
   logic [7:0] seg_pos4;
   logic [7:0] seg_pos5;

   modport source (output valid, output seg_pos0, output seg_pos1, output seg_pos2,
                   output seg_pos3, output seg_pos4, output seg_pos5, input ready);
   modport sink   (input valid, input seg_pos0, input seg_pos1, input seg_pos2,
                   input seg_pos3, input seg_pos4, input seg_pos5, output ready);
endinterface
`default_nettype wire

@@ rtl/core/decimal_seven_segment_formatter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_seven_segment_formatter: six-digit 7-segment display formatter
// Converts a binary reading to six segment codes with scaling, sign and point.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output is not stalled and returns one
// word of six segment codes per word, leftmost position first. Each word
// passes through the four double-dabble stages (five bit steps each) that
// turn the 20-bit reading into seven BCD digits, then the output register
// where scaling, saturation and layout are done. Division by 10, 100 or
// 1000 simply drops BCD digits; an unscaled reading above 999999 shows
// 999999. Positive words show up to six digits, with unused upper positions
// blank or '0' per leading_zero_fill. Negative words show at most five
// digits with a minus directly left of the highest one; tens and ones always
// show. Segment bit 7 is the point, bits 6..0 are g..a. The whole pipe
// moves only when the output register is empty or being read, so a stall
// holds every stage in place. CSR writes (index 0 scale_select, index 1
// leading_zero_fill) take effect at the format stage and belong in idle time.
// ----------------------------------------------------------------------------
module decimal_seven_segment_formatter (
   input  wire logic                             clock,
   input  wire logic                             reset,
   dsf_req_if.sink                               req_bus,
   dsf_rsp_if.source                             rsp_bus,
   input  wire logic                             csr_write_enable,
   input  wire logic [dsf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [dsf_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   // config registers
   logic [dsf_pkg::SCALE_W-1:0] scale_ff;
   logic                        fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= dsf_pkg::SCALE_RESET;
         fill_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            dsf_pkg::CSR_SCALE_SELECT:      scale_ff <= csr_write_data;
            dsf_pkg::CSR_LEADING_ZERO_FILL: fill_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // global advance: output slot free or being drained
   logic rsp_valid;
   logic advance;

   assign advance       = !rsp_valid || rsp_bus.ready;
   assign req_bus.ready = advance;

   // stage 0 is the incoming word
   logic                  stage_valid [dsf_pkg::BCD_STAGES+1];
   dsf_pkg::bcd_word_type stage_work  [dsf_pkg::BCD_STAGES+1];

   assign stage_valid[0]    = req_bus.valid;
   assign stage_work[0].bcd = '0;
   assign stage_work[0].bin = req_bus.reading;
   assign stage_work[0].dot = req_bus.dot_position;
   assign stage_work[0].neg = req_bus.negative;

   for (genvar g = 0; g < dsf_pkg::BCD_STAGES; g++) begin : g_bcd
      dsf_bcd_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[g]),
         .in_work   (stage_work[g]),
         .out_valid (stage_valid[g+1]),
         .out_work  (stage_work[g+1])
      );
   end

   dsf_pkg::seg_row_type seg;

   dsf_seg_format u_format (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .in_valid          (stage_valid[dsf_pkg::BCD_STAGES]),
      .in_work           (stage_work[dsf_pkg::BCD_STAGES]),
      .scale_select      (scale_ff),
      .leading_zero_fill (fill_ff),
      .out_valid         (rsp_valid),
      .out_seg           (seg)
   );

   assign rsp_bus.valid    = rsp_valid;
   assign rsp_bus.seg_pos0 = seg[0];
   assign rsp_bus.seg_pos1 = seg[1];
   assign rsp_bus.seg_pos2 = seg[2];
   assign rsp_bus.seg_pos3 = seg[3];
   assign rsp_bus.seg_pos4 = seg[4];
   assign rsp_bus.seg_pos5 = seg[5];

endmodule
`default_nettype wire

@@ rtl/core/dsf_bcd_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dsf_bcd_stage: one double-dabble pipeline stage
// Shifts STAGE_STEPS binary bits into the BCD accumulator, add-3 per digit.
// ----------------------------------------------------------------------------
module dsf_bcd_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  wire dsf_pkg::bcd_word_type in_work,
   output logic                       out_valid,
   output dsf_pkg::bcd_word_type      out_work
);

   logic                          valid_ff;
   dsf_pkg::bcd_word_type         work_ff;
   dsf_pkg::bcd_word_type         work_in;

   always_comb begin
      logic [dsf_pkg::BCD_W-1:0]     b;
      logic [dsf_pkg::READING_W-1:0] r;
      b = in_work.bcd;
      r = in_work.bin;
      for (int s = 0; s < dsf_pkg::STAGE_STEPS; s++) begin
         for (int k = 0; k < dsf_pkg::DIGITS; k++) begin
            if (b[4*k +: 4] >= 4'd5) begin
               b[4*k +: 4] = b[4*k +: 4] + 4'd3;
            end
         end
         {b, r} = {b[dsf_pkg::BCD_W-2:0], r, 1'b0};
      end
      work_in     = in_work;
      work_in.bcd = b;
      work_in.bin = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule
`default_nettype wire

@@ rtl/core/dsf_seg_format.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dsf_seg_format: scaling, saturation and segment encoding
// Drops BCD digits for the divide, saturates, lays out digits, sign and
// point, and holds the result in the output register.
// ----------------------------------------------------------------------------
module dsf_seg_format (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic                         in_valid,
   input  wire dsf_pkg::bcd_word_type        in_work,
   input  wire logic [dsf_pkg::SCALE_W-1:0]  scale_select,
   input  wire logic                         leading_zero_fill,
   output logic                              out_valid,
   output dsf_pkg::seg_row_type              out_seg
);

   logic                  valid_ff;
   dsf_pkg::seg_row_type  seg_ff;
   dsf_pkg::seg_row_type  seg_in;

   always_comb begin
      logic [3:0] s [dsf_pkg::DIGITS];
      logic [1:0] shift;
      logic       ge100;
      logic       ge1000;
      logic       ge10000;
      logic       ge100000;
      dsf_pkg::seg_type fill;

      case (scale_select) inside
         dsf_pkg::SCALE_DIV10:  shift = 2'd1;
         dsf_pkg::SCALE_DIV100: shift = 2'd2;
         [dsf_pkg::SCALE_DIV1000_LOW:dsf_pkg::SCALE_DIV1000_HIGH]: shift = 2'd3;
         default:               shift = 2'd0;
      endcase

      // s[0] is the ones digit of the scaled value
      for (int k = 0; k < dsf_pkg::DIGITS; k++) begin
         if (k + int'(shift) < dsf_pkg::DIGITS) begin
            s[k] = in_work.bcd[4*(k + int'(shift)) +: 4];
         end else begin
            s[k] = 4'd0;
         end
      end

      // millions digit only survives unscaled: clamp to 999999
      if (s[6] != 4'd0) begin
         for (int k = 0; k < dsf_pkg::DIGITS - 1; k++) begin
            s[k] = 4'd9;
         end
      end

      ge100000 = (s[5] != 4'd0);
      ge10000  = ge100000 || (s[4] != 4'd0);
      ge1000   = ge10000 || (s[3] != 4'd0);
      ge100    = ge1000 || (s[2] != 4'd0);

      seg_in[4] = dsf_pkg::digit_seg(s[1]);
      seg_in[5] = dsf_pkg::digit_seg(s[0]);

      if (in_work.neg) begin
         seg_in[0] = ge10000 ? dsf_pkg::SEG_MINUS : dsf_pkg::SEG_BLANK;
         seg_in[1] = ge10000 ? dsf_pkg::digit_seg(s[4])
                   : (ge1000 ? dsf_pkg::SEG_MINUS : dsf_pkg::SEG_BLANK);
         seg_in[2] = ge1000 ? dsf_pkg::digit_seg(s[3])
                   : (ge100 ? dsf_pkg::SEG_MINUS : dsf_pkg::SEG_BLANK);
         seg_in[3] = ge100 ? dsf_pkg::digit_seg(s[2]) : dsf_pkg::SEG_MINUS;
      end else begin
         fill      = leading_zero_fill ? dsf_pkg::digit_seg(4'd0) : dsf_pkg::SEG_BLANK;
         seg_in[0] = ge100000 ? dsf_pkg::digit_seg(s[5]) : fill;
         seg_in[1] = ge10000  ? dsf_pkg::digit_seg(s[4]) : fill;
         seg_in[2] = ge1000   ? dsf_pkg::digit_seg(s[3]) : fill;
         seg_in[3] = ge100    ? dsf_pkg::digit_seg(s[2]) : fill;
      end

      case (in_work.dot) inside
         dsf_pkg::DOT_POS0: seg_in[0] = seg_in[0] | dsf_pkg::SEG_POINT;
         dsf_pkg::DOT_POS1: seg_in[1] = seg_in[1] | dsf_pkg::SEG_POINT;
         dsf_pkg::DOT_POS2: seg_in[2] = seg_in[2] | dsf_pkg::SEG_POINT;
         dsf_pkg::DOT_POS3: seg_in[3] = seg_in[3] | dsf_pkg::SEG_POINT;
         [dsf_pkg::DOT_POS4_LOW:dsf_pkg::DOT_POS4_HI]:
            seg_in[4] = seg_in[4] | dsf_pkg::SEG_POINT;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         seg_ff <= seg_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_seg   = seg_ff;

endmodule
`default_nettype wire

@@ rtl/core/dsf_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dsf_checker: port-level checks for the formatter
// Watches the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
module dsf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] seg_pos0,
   input wire logic [7:0] seg_pos1,
   input wire logic [7:0] seg_pos2,
   input wire logic [7:0] seg_pos3,
   input wire logic [7:0] seg_pos4,
   input wire logic [7:0] seg_pos5
);

   // stalled word holds: valid, seg_pos0, seg_pos4 and seg_pos5 stay put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(seg_pos0) && $stable(seg_pos4)
         && $stable(seg_pos5))
      else $error("stalled response changed");

   // input side only blocks behind a stalled output
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request blocked without output stall");

   // ones position never carries the point
   a_no_dot5: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !seg_pos5[7])
      else $error("point on ones digit");

   // at most one point per word
   a_one_dot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({seg_pos0[7], seg_pos1[7], seg_pos2[7], seg_pos3[7],
                              seg_pos4[7]}))
      else $error("more than one point");

   // pipe empty right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind decimal_seven_segment_formatter dsf_checker u_dsf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .seg_pos0  (rsp_bus.seg_pos0),
   .seg_pos1  (rsp_bus.seg_pos1),
   .seg_pos2  (rsp_bus.seg_pos2),
   .seg_pos3  (rsp_bus.seg_pos3),
   .seg_pos4  (rsp_bus.seg_pos4),
   .seg_pos5  (rsp_bus.seg_pos5)
);
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: decimal seven-segment formatter
// Drives readings through the valid/ready request channel under bursty
// traffic and a stalling receiver. Every accepted word gets an expected
// display, typed into the table or predicted here, and each response is
// checked field by field. Runs a directed table, then random phases across
// scale and zero-fill settings.
module testbench;

   localparam int          WATCHDOG_LIMIT  = 3000;
   localparam int          ITEMS_PER_PHASE = 181;
   localparam int          HOLD_CYCLES     = 400;   // long receiver hold-off
   localparam int          DRAIN_CYCLES    = 8;     // drain wait after the last word, longer than the pipe
   localparam int unsigned VALUE_MAX       = 999999;
   localparam int unsigned READING_MAX     = (1 << dsf_pkg::READING_W) - 1;
   localparam logic [dsf_pkg::DOT_W-1:0] DOT_NONE = 3'd7;

   // digit segment codes, index 9 first
   localparam logic [9:0][7:0] DIGIT_CODE = {8'h6f, 8'h7f, 8'h27, 8'h7d, 8'h6d,
                                             8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};

   // six segment codes, leftmost position first
   typedef struct packed {
      dsf_pkg::seg_type pos0;
      dsf_pkg::seg_type pos1;
      dsf_pkg::seg_type pos2;
      dsf_pkg::seg_type pos3;
      dsf_pkg::seg_type pos4;
      dsf_pkg::seg_type pos5;
   } display_word_type;

   // one row of the directed table; known=1 means the display is typed in
   typedef struct packed {
      logic [dsf_pkg::READING_W-1:0] reading;
      logic [dsf_pkg::DOT_W-1:0]     dot;
      logic                          neg;
      logic                          known;
      display_word_type              display;
   } directed_row_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_write_enable;
   logic [dsf_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [dsf_pkg::CSR_DATA_W-1:0]  csr_write_data;

   dsf_req_if req_bus ();
   dsf_rsp_if rsp_bus ();

   decimal_seven_segment_formatter uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // local copy of the two registers, tracked on every write
   logic [dsf_pkg::SCALE_W-1:0] scale_setting = dsf_pkg::SCALE_RESET;
   logic                        zero_fill_setting = 1'b0;

   display_word_type pending_displays [$];   // expected words, oldest first
   directed_row_type directed_rows [$];
   int               error_count = 0;
   int               idle_cycles = 0;
   int               burst_left = 0;
   bit               hold_request = 0;       // main asks the receiver for a long hold

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor: scale, saturate, split into digits, lay out, place the point.
   // ------------------------------------------------------------------------
   function automatic display_word_type format_reading(
         input logic [dsf_pkg::READING_W-1:0] reading,
         input logic [dsf_pkg::DOT_W-1:0] dot,
         input logic neg);
      int unsigned      value;
      int unsigned      rest;
      int unsigned      digit [6];
      dsf_pkg::seg_type pos [6];
      dsf_pkg::seg_type fill;
      display_word_type word;
      int               k;
      value = 32'(reading);
      if (scale_setting == dsf_pkg::SCALE_DIV10) begin
         value = value / 10;
      end else if (scale_setting == dsf_pkg::SCALE_DIV100) begin
         value = value / 100;
      end else if (scale_setting <= dsf_pkg::SCALE_DIV1000_HIGH) begin
         value = value / 1000;
      end
      if (value > VALUE_MAX) begin
         value = VALUE_MAX;
      end
      rest = value;
      for (k = 5; k >= 0; k--) begin
         digit[k] = rest % 10;
         rest = rest / 10;
      end
      pos[4] = DIGIT_CODE[digit[4][3:0]];
      pos[5] = DIGIT_CODE[digit[5][3:0]];
      if (neg) begin
         // minus walks left as the value grows; fill setting plays no part
         pos[0] = dsf_pkg::SEG_BLANK;
         pos[1] = dsf_pkg::SEG_BLANK;
         pos[2] = dsf_pkg::SEG_BLANK;
         pos[3] = dsf_pkg::SEG_MINUS;
         if (value >= 100) begin
            pos[2] = dsf_pkg::SEG_MINUS;
            pos[3] = DIGIT_CODE[digit[3][3:0]];
         end
         if (value >= 1000) begin
            pos[1] = dsf_pkg::SEG_MINUS;
            pos[2] = DIGIT_CODE[digit[2][3:0]];
         end
         if (value >= 10000) begin
            // top digit simply falls off for six-digit values
            pos[0] = dsf_pkg::SEG_MINUS;
            pos[1] = DIGIT_CODE[digit[1][3:0]];
         end
      end else begin
         fill = zero_fill_setting ? DIGIT_CODE[0] : dsf_pkg::SEG_BLANK;
         pos[0] = fill;
         pos[1] = fill;
         pos[2] = fill;
         pos[3] = fill;
         if (value >= 100) pos[3] = DIGIT_CODE[digit[3][3:0]];
         if (value >= 1000) pos[2] = DIGIT_CODE[digit[2][3:0]];
         if (value >= 10000) pos[1] = DIGIT_CODE[digit[1][3:0]];
         if (value >= 100000) pos[0] = DIGIT_CODE[digit[0][3:0]];
      end
      // point goes on regardless of what the position shows
      case (dot)
         dsf_pkg::DOT_POS0: pos[0] = pos[0] | dsf_pkg::SEG_POINT;
         dsf_pkg::DOT_POS1: pos[1] = pos[1] | dsf_pkg::SEG_POINT;
         dsf_pkg::DOT_POS2: pos[2] = pos[2] | dsf_pkg::SEG_POINT;
         dsf_pkg::DOT_POS3: pos[3] = pos[3] | dsf_pkg::SEG_POINT;
         default: begin
            if (dot <= dsf_pkg::DOT_POS4_HI) pos[4] = pos[4] | dsf_pkg::SEG_POINT;
         end
      endcase
      word.pos0 = pos[0];
      word.pos1 = pos[1];
      word.pos2 = pos[2];
      word.pos3 = pos[3];
      word.pos4 = pos[4];
      word.pos5 = pos[5];
      return word;
   endfunction

   // Random reading: full 20-bit range, each magnitude band, and values
   // right at the decimal thresholds after the current division.
   function automatic logic [dsf_pkg::READING_W-1:0] pick_reading();
      longint unsigned divisor;
      longint unsigned value;
      if (scale_setting == dsf_pkg::SCALE_DIV10) divisor = 10;
      else if (scale_setting == dsf_pkg::SCALE_DIV100) divisor = 100;
      else if (scale_setting <= dsf_pkg::SCALE_DIV1000_HIGH) divisor = 1000;
      else divisor = 1;
      case ($urandom_range(0, 5))
         0: value = $urandom_range(0, READING_MAX);
         1: value = $urandom_range(0, 99);
         2: value = $urandom_range(100, 9999);
         3: value = $urandom_range(10000, VALUE_MAX);
         default: begin
            value = (10 ** $urandom_range(0, 6)) * divisor;
            value = value + $urandom_range(0, 2) - 1;
         end
      endcase
      if (value > READING_MAX) value = READING_MAX;
      return value[dsf_pkg::READING_W-1:0];
   endfunction

   // Offer one word, in bursts with random gaps; returns once accepted.
   task automatic send_reading(input logic [dsf_pkg::READING_W-1:0] reading,
                               input logic [dsf_pkg::DOT_W-1:0] dot,
                               input logic neg,
                               input display_word_type expected);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_bus.valid        <= 1'b1;
      req_bus.reading      <= reading;
      req_bus.dot_position <= dot;
      req_bus.negative     <= neg;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_displays.push_back(expected);
      burst_left--;
   endtask

   // Write both registers back to back; only called with the pipe empty.
   task automatic apply_settings(input logic [dsf_pkg::SCALE_W-1:0] scale,
                                 input logic fill);
      csr_write_enable <= 1'b1;
      csr_index        <= dsf_pkg::CSR_SCALE_SELECT;
      csr_write_data   <= scale;
      @(posedge clock);
      scale_setting = scale;
      csr_index      <= dsf_pkg::CSR_LEADING_ZERO_FILL;
      csr_write_data <= {{(dsf_pkg::CSR_DATA_W-1){1'b0}}, fill};
      @(posedge clock);
      zero_fill_setting = fill;
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (pending_displays.size() != 0) @(posedge clock);
   endtask

   task automatic check_display(input display_word_type got);
      display_word_type want;
      logic [47:0]      got_bits;
      logic [47:0]      want_bits;
      int               k;
      if (pending_displays.size() == 0) begin
         $error("unexpected response word %h", got);
         error_count++;
      end else begin
         want = pending_displays.pop_front();
         got_bits = got;
         want_bits = want;
         for (k = 0; k < dsf_pkg::POSITIONS; k++) begin
            if (got_bits[47-8*k -: 8] !== want_bits[47-8*k -: 8]) begin
               $error("seg_pos%0d: expected %h, actual %h",
                      k, want_bits[47-8*k -: 8], got_bits[47-8*k -: 8]);
               error_count++;
            end
         end
      end
   endtask

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         check_display({rsp_bus.seg_pos0, rsp_bus.seg_pos1, rsp_bus.seg_pos2,
                        rsp_bus.seg_pos3, rsp_bus.seg_pos4, rsp_bus.seg_pos5});
      end
   end

   // Watchdog: ends the run after too long with no word moving either way
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: segments of differing stall patterns, plus one long hold
   initial begin : receiver
      int mode;
      int seg_len;
      int n;
      forever begin
         if (hold_request) begin
            for (n = 0; n < HOLD_CYCLES; n++) begin
               @(posedge clock);
               rsp_bus.ready <= 1'b0;
            end
            hold_request = 0;
         end else begin
            mode = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 60);
            for (n = 0; n < seg_len; n++) begin
               @(posedge clock);
               case (mode)
                  0: rsp_bus.ready <= 1'b1;                         // free-flowing
                  1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);  // light stalls
                  2: rsp_bus.ready <= ((n % 5) < 2);                // periodic
                  default: rsp_bus.ready <= 1'($urandom_range(0, 1)); // heavy stalls
               endcase
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main
      logic [dsf_pkg::SCALE_W-1:0]   phase_scale [9];
      logic                          phase_fill [9];
      directed_row_type              row;
      display_word_type              expected;
      logic [dsf_pkg::READING_W-1:0] reading;
      logic [dsf_pkg::DOT_W-1:0]     dot;
      logic                          neg;
      int                            p;
      int                            i;

      clock                = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.reading      = '0;
      req_bus.dot_position = '0;
      req_bus.negative     = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_write_enable     = 1'b0;
      csr_index            = '0;
      csr_write_data       = '0;

      // directed table, run at the reset settings (no scaling, blank fill)
      directed_rows.push_back(directed_row_type'{20'd0, DOT_NONE, 1'b0, 1'b1,
                                                 48'h00_00_00_00_3f_3f});
      directed_rows.push_back(directed_row_type'{20'd999999, DOT_NONE, 1'b0, 1'b1,
                                                 48'h6f_6f_6f_6f_6f_6f});
      // large unscaled reading saturates
      directed_rows.push_back(directed_row_type'{20'hfffff, DOT_NONE, 1'b0, 1'b1,
                                                 48'h6f_6f_6f_6f_6f_6f});
      directed_rows.push_back(directed_row_type'{20'hfffff, DOT_NONE, 1'b1, 1'b1,
                                                 48'h40_6f_6f_6f_6f_6f});
      // negative, small values: minus walks left at 100, 1000, 10000
      directed_rows.push_back(directed_row_type'{20'd5, DOT_NONE, 1'b1, 1'b1,
                                                 48'h00_00_00_40_3f_6d});
      directed_rows.push_back(directed_row_type'{20'd99, DOT_NONE, 1'b1, 1'b1,
                                                 48'h00_00_00_40_6f_6f});
      directed_rows.push_back(directed_row_type'{20'd100, DOT_NONE, 1'b1, 1'b1,
                                                 48'h00_00_40_06_3f_3f});
      directed_rows.push_back(directed_row_type'{20'd1000, DOT_NONE, 1'b1, 1'b1,
                                                 48'h00_40_06_3f_3f_3f});
      directed_rows.push_back(directed_row_type'{20'd10000, DOT_NONE, 1'b1, 1'b1,
                                                 48'h40_06_3f_3f_3f_3f});
      // negative six-digit value drops its top digit
      directed_rows.push_back(directed_row_type'{20'd123456, DOT_NONE, 1'b1, 1'b1,
                                                 48'h40_5b_4f_66_6d_7d});
      directed_rows.push_back(directed_row_type'{20'd123456, DOT_NONE, 1'b0, 1'b1,
                                                 48'h06_5b_4f_66_6d_7d});
      // every point position, including on a blank and on the minus
      directed_rows.push_back(directed_row_type'{20'd0, dsf_pkg::DOT_POS0, 1'b0, 1'b1,
                                                 48'h80_00_00_00_3f_3f});
      directed_rows.push_back(directed_row_type'{20'd0, dsf_pkg::DOT_POS1, 1'b0, 1'b1,
                                                 48'h00_80_00_00_3f_3f});
      directed_rows.push_back(directed_row_type'{20'd0, dsf_pkg::DOT_POS2, 1'b0, 1'b1,
                                                 48'h00_00_80_00_3f_3f});
      directed_rows.push_back(directed_row_type'{20'd0, dsf_pkg::DOT_POS3, 1'b1, 1'b1,
                                                 48'h00_00_00_c0_3f_3f});
      directed_rows.push_back(directed_row_type'{20'd0, 3'd0, 1'b0, 1'b1,
                                                 48'h00_00_00_00_bf_3f});
      directed_rows.push_back(directed_row_type'{20'd0, 3'd1, 1'b1, 1'b1,
                                                 48'h00_00_00_40_bf_3f});
      directed_rows.push_back(directed_row_type'{20'd0, 3'd2, 1'b0, 1'b1,
                                                 48'h00_00_00_00_bf_3f});
      // rows left to the predictor
      directed_rows.push_back(directed_row_type'{20'd99999, dsf_pkg::DOT_POS0, 1'b1, 1'b0,
                                                 48'h0});
      directed_rows.push_back(directed_row_type'{20'd54321, dsf_pkg::DOT_POS3, 1'b0, 1'b0,
                                                 48'h0});
      directed_rows.push_back(directed_row_type'{20'd9, dsf_pkg::DOT_POS1, 1'b1, 1'b0,
                                                 48'h0});
      directed_rows.push_back(directed_row_type'{20'd100000, dsf_pkg::DOT_POS2, 1'b0, 1'b0,
                                                 48'h0});
      directed_rows.push_back(directed_row_type'{20'd678901, 3'd2, 1'b1, 1'b0, 48'h0});
      directed_rows.push_back(directed_row_type'{20'd12, 3'd0, 1'b0, 1'b0, 48'h0});
      directed_rows.push_back(directed_row_type'{20'h80000, DOT_NONE, 1'b0, 1'b0, 48'h0});

      // settings per random phase, extremes included
      phase_scale = '{3'd0, 3'd2, 3'd3, 3'd4, 3'd5, 3'd7, 3'd1, 3'd6, 3'd4};
      phase_fill  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         expected = row.known ? row.display : format_reading(row.reading, row.dot, row.neg);
         send_reading(row.reading, row.dot, row.neg, expected);
      end
      wait_drained();

      for (p = 0; p < 9; p++) begin
         apply_settings(phase_scale[p], phase_fill[p]);
         if (p == 2) hold_request = 1;   // back up the pipe once
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            reading = pick_reading();
            dot = dsf_pkg::DOT_W'($urandom_range(0, 7));
            neg = 1'($urandom_range(0, 1));
            send_reading(reading, dot, neg, format_reading(reading, dot, neg));
         end
         wait_drained();
      end

      // any stray word after the last expected one is flagged by the monitor
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
